// ===== hw/rtl/rrs_pkg.sv =====
// Shared types and constants for the rolling return standard deviation block.
package rrs_pkg;

   localparam int MID_W  = 32;
   localparam int CSR_W  = 11;
   localparam int STD_W  = 27;
   localparam int CNT_OUT_W = 11;

   localparam logic [CSR_W-1:0] WIN_RESET = 11'd1024;
   localparam logic [STD_W-1:0] STD_MAX   = {STD_W{1'b1}};

   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef struct packed {
      logic             cmd;
      logic [MID_W-1:0] mid_quote;
   } req_type;

   typedef struct packed {
      logic                 std_valid;
      logic [STD_W-1:0]     std_value;
      logic [CNT_OUT_W-1:0] return_count;
      logic                 bad_price;
   } rsp_type;

endpackage

// ===== hw/rtl/rrs_ring.sv =====
// Return ring memory with one write port and one registered read port.
module rrs_ring #(
   parameter int DEPTH = 1024,
   parameter int W     = 28
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [W-1:0]             wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [W-1:0]             rd_data
);

   logic [W-1:0] mem [DEPTH];
   logic [W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rrs_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module rrs_div #(
   parameter int NW = 56,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [NW-1:0] quo
);

   localparam int CW = $clog2(NW + 1);

   logic          busy_ff;
   logic [CW-1:0] cnt_ff;
   logic [NW-1:0] quo_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;

   logic [DW:0] rem_sh;
   logic        ge;
   logic [DW:0] rem_in;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[NW-1]};
      ge     = rem_sh >= {1'b0, den_ff};
      rem_in = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(NW);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NW-2:0], ge};
         rem_ff <= rem_in[DW-1:0];
      end
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

// ===== hw/rtl/rrs_mul.sv =====
// Shift-and-add multiplier that consumes one multiplier bit per cycle.
module rrs_mul #(
   parameter int AW = 64,
   parameter int BW = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic             busy,
   output logic [AW+BW-1:0] prod
);

   localparam int CW = $clog2(BW + 1);

   logic             busy_ff;
   logic [CW-1:0]    cnt_ff;
   logic [AW-1:0]    a_ff;
   logic [BW-1:0]    b_ff;
   logic [AW+BW-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(BW);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= {acc_ff[AW+BW-2:0], 1'b0} + (b_ff[BW-1] ? (AW+BW)'(a_ff) : '0);
         b_ff   <= {b_ff[BW-2:0], 1'b0};
      end
   end

   assign busy = busy_ff;
   assign prod = acc_ff;

endmodule

// ===== hw/rtl/rrs_sqrt.sv =====
// Integer square root that settles one root bit per cycle.
module rrs_sqrt #(
   parameter int RW = 28
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [2*RW-1:0] value,
   output logic            busy,
   output logic [RW-1:0]   root
);

   localparam int CW = $clog2(RW + 1);

   logic            busy_ff;
   logic [CW-1:0]   cnt_ff;
   logic [2*RW-1:0] v_ff;
   logic [RW+1:0]   rem_ff;
   logic [RW-1:0]   root_ff;

   logic [RW+3:0] rem_sh;
   logic [RW+3:0] trial;
   logic          ge;
   logic [RW+3:0] rem_in;

   always_comb begin
      rem_sh = {rem_ff, v_ff[2*RW-1:2*RW-2]};
      trial  = {2'b00, root_ff, 2'b01};
      ge     = rem_sh >= trial;
      rem_in = ge ? rem_sh - trial : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(RW);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff    <= value;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         v_ff    <= {v_ff[2*RW-3:0], 2'b00};
         rem_ff  <= rem_in[RW+1:0];
         root_ff <= {root_ff[RW-2:0], ge};
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// ===== hw/rtl/rolling_return_stddev_top.sv =====
// Top level of the rolling return standard deviation block.
// This block takes mid prices in half-tick units and, from the second price on, forms the
// relative return (mid - last) / last in signed Q3.FRAC_BITS, truncated toward zero and
// saturated. Returns are kept in a ring memory of MAX_WINDOW entries together with an exact
// running sum and sum of squares; csr_data sets how many of the newest returns are kept
// (zero acts as one, anything above MAX_WINDOW acts as MAX_WINDOW), and a change takes
// effect at the next return, when the oldest returns are dropped one by one. Every return
// gives one result item carrying the population standard deviation of the window in
// unsigned Q.FRAC_BITS. The clear command empties the window and forgets the last price; a
// zero price is rejected with bad_price set and changes nothing. One item is processed at a
// time. A clear, a rejected price or the first price goes from acceptance straight to the
// output state. A return passes through the bit-serial return divider, a ring read plus
// square and subtract for each dropped return, the window update, the serial multipliers,
// the start of the variance divider, that divider, the serial square root and the output
// state; when the variance comes out as zero, the return goes from the multipliers straight
// to the output state. The result sits in an output register, so the next item can be taken
// while that result still waits. The ring needs no clearing after reset since only counted
// entries are ever read.
module rolling_return_stddev_top #(
   parameter int MAX_WINDOW = 1024,
   parameter int FRAC_BITS  = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rrs_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rrs_pkg::rsp_type      rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [rrs_pkg::CSR_W-1:0] csr_data
);

   import rrs_pkg::*;

   // Widths of the datapath, following from the two parameters and MID_W.
   localparam int RET_W  = FRAC_BITS + 4;
   localparam int AW     = $clog2(MAX_WINDOW);
   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int IW     = CNT_W + 1;
   localparam int SUM_W  = RET_W + AW;
   // The sum of squares is exact for small sizes and wraps at 64 bits like the full size.
   localparam int SQ_W   = (2 * RET_W - 1 + AW > 64) ? 64 : 2 * RET_W - 1 + AW;
   localparam int PROD_W = SQ_W + CNT_W;
   localparam int S2_W   = 2 * SUM_W;
   localparam int BIG_W  = (PROD_W > S2_W) ? PROD_W : S2_W;
   localparam int N2_W   = 2 * CNT_W;
   localparam int NUM_W  = MID_W + FRAC_BITS;

   localparam logic [NUM_W-1:0] RET_POS_MAX = NUM_W'((64'd1 << (RET_W - 1)) - 64'd1);
   localparam logic [NUM_W-1:0] RET_NEG_MAG = NUM_W'(64'd1 << (RET_W - 1));

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_CHK, ST_DRD, ST_DUPD, ST_INS, ST_INS2,
      ST_MSTART, ST_MUL, ST_DSTART, ST_VDIV, ST_SQRT, ST_OUT
   } state_type;

   state_type state_ff;

   // Architectural state.
   logic [CSR_W-1:0]        window_ff;
   logic [MID_W-1:0]        last_ff;
   logic                    have_last_ff;
   logic [AW-1:0]           head_ff;
   logic [CNT_W-1:0]        filled_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [SQ_W-1:0]         sqsum_ff;

   // Working registers of the item in flight.
   logic [MID_W-1:0]        mid_ff;
   logic                    neg_ff;
   logic signed [RET_W-1:0] ret_ff;
   logic signed [RET_W-1:0] old_ff;
   logic [SQ_W-1:0]         sq_ff;
   logic [N2_W-1:0]         n2_ff;
   logic [BIG_W-1:0]        diff_ff;
   logic                    res_valid_ff;
   logic [STD_W-1:0]        res_std_ff;
   logic                    res_bad_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic                    accept;
   logic                    rd_en;
   logic [AW-1:0]           rd_idx;
   logic [RET_W-1:0]        rd_data;
   logic [IW-1:0]           idx_tmp;
   logic [CSR_W-1:0]        len_eff;
   logic                    need_drop;
   logic                    out_load;

   logic                    rdiv_start;
   logic                    rdiv_busy;
   logic [NUM_W-1:0]        rdiv_num;
   logic [MID_W-1:0]        rdiv_mag;
   logic [NUM_W-1:0]        rdiv_quo;
   logic signed [RET_W-1:0] ret_sat;

   logic                    mul_start;
   logic                    mula_busy;
   logic                    mulb_busy;
   logic [PROD_W-1:0]       prod_a;
   logic [S2_W-1:0]         prod_b;
   logic [SUM_W-1:0]        sum_mag;
   logic [BIG_W-1:0]        big_a;
   logic [BIG_W-1:0]        big_b;

   logic                    vdiv_start;
   logic                    vdiv_busy;
   logic [BIG_W-1:0]        vdiv_quo;
   logic                    sqrt_start;
   logic                    sqrt_busy;
   logic [RET_W-1:0]        sqrt_root;

   logic signed [RET_W-1:0] sq_src;
   logic [RET_W-1:0]        sq_mag;
   logic [2*RET_W-1:0]      sq_full;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // Effective window length: zero keeps one return, too large keeps the whole ring.
   always_comb begin
      len_eff = window_ff;
      if (window_ff == '0) begin
         len_eff = CSR_W'(1);
      end else if (window_ff > CSR_W'(MAX_WINDOW)) begin
         len_eff = CSR_W'(MAX_WINDOW);
      end
   end

   assign need_drop = CSR_W'(filled_ff) >= len_eff;

   // Slot of the oldest return: head minus count, modulo the ring depth.
   always_comb begin
      idx_tmp = IW'(head_ff) + IW'(MAX_WINDOW) - IW'(filled_ff);
      if (idx_tmp >= IW'(MAX_WINDOW)) begin
         idx_tmp = idx_tmp - IW'(MAX_WINDOW);
      end
      rd_idx = idx_tmp[AW-1:0];
   end

   assign rd_en = (state_ff == ST_CHK) && need_drop;

   // Return divider operands: magnitude of the price change scaled up by the fraction bits.
   assign rdiv_start = accept && (req_data.cmd == CMD_PUSH) && (req_data.mid_quote != '0)
                       && have_last_ff;
   assign rdiv_mag   = (req_data.mid_quote >= last_ff) ? req_data.mid_quote - last_ff
                                                       : last_ff - req_data.mid_quote;
   assign rdiv_num   = NUM_W'(rdiv_mag) << FRAC_BITS;

   // Truncated quotient with the sign put back, saturated to the return width.
   always_comb begin
      if (neg_ff) begin
         ret_sat = (rdiv_quo > RET_NEG_MAG) ? -RET_W'(RET_NEG_MAG) : -RET_W'(rdiv_quo);
      end else begin
         ret_sat = (rdiv_quo > RET_POS_MAX) ? RET_W'(RET_POS_MAX) : RET_W'(rdiv_quo);
      end
   end

   // One squarer, shared by the dropped return and the new return.
   always_comb begin
      sq_src  = (state_ff == ST_DRD) ? RET_W'(rd_data) : ret_ff;
      sq_mag  = sq_src[RET_W-1] ? RET_W'(-sq_src) : RET_W'(sq_src);
      sq_full = (2*RET_W)'(sq_mag) * (2*RET_W)'(sq_mag);
   end

   assign sum_mag   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign mul_start = (state_ff == ST_MSTART);
   assign big_a     = BIG_W'(prod_a);
   assign big_b     = BIG_W'(prod_b);
   assign vdiv_start = (state_ff == ST_DSTART);
   assign sqrt_start = (state_ff == ST_VDIV) && !vdiv_busy;
   assign out_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   rrs_ring #(.DEPTH(MAX_WINDOW), .W(RET_W)) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == ST_INS),
      .wr_addr (head_ff),
      .wr_data (RET_W'(ret_ff)),
      .rd_en   (rd_en),
      .rd_addr (rd_idx),
      .rd_data (rd_data)
   );

   rrs_div #(.NW(NUM_W), .DW(MID_W)) u_rdiv (
      .clock (clock),
      .reset (reset),
      .start (rdiv_start),
      .num   (rdiv_num),
      .den   (last_ff),
      .busy  (rdiv_busy),
      .quo   (rdiv_quo)
   );

   rrs_mul #(.AW(SQ_W), .BW(CNT_W)) u_mula (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (sqsum_ff),
      .b     (filled_ff),
      .busy  (mula_busy),
      .prod  (prod_a)
   );

   rrs_mul #(.AW(SUM_W), .BW(SUM_W)) u_mulb (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (sum_mag),
      .b     (sum_mag),
      .busy  (mulb_busy),
      .prod  (prod_b)
   );

   rrs_div #(.NW(BIG_W), .DW(N2_W)) u_vdiv (
      .clock (clock),
      .reset (reset),
      .start (vdiv_start),
      .num   (diff_ff),
      .den   (n2_ff),
      .busy  (vdiv_busy),
      .quo   (vdiv_quo)
   );

   // The variance never reaches 2^(2*RET_W-2), so the low quotient bits hold it exactly.
   rrs_sqrt #(.RW(RET_W)) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (vdiv_quo[2*RET_W-1:0]),
      .busy  (sqrt_busy),
      .root  (sqrt_root)
   );

   // Sequencer together with the window state and the result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WIN_RESET;
         last_ff      <= '0;
         have_last_ff <= 1'b0;
         head_ff      <= '0;
         filled_ff    <= '0;
         sum_ff       <= '0;
         sqsum_ff     <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            window_ff <= csr_data;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  mid_ff       <= req_data.mid_quote;
                  neg_ff       <= req_data.mid_quote < last_ff;
                  res_valid_ff <= 1'b0;
                  res_std_ff   <= '0;
                  res_bad_ff   <= 1'b0;
                  if (req_data.cmd == CMD_CLEAR) begin
                     last_ff      <= '0;
                     have_last_ff <= 1'b0;
                     head_ff      <= '0;
                     filled_ff    <= '0;
                     sum_ff       <= '0;
                     sqsum_ff     <= '0;
                     state_ff     <= ST_OUT;
                  end else if (req_data.mid_quote == '0) begin
                     res_bad_ff <= 1'b1;
                     state_ff   <= ST_OUT;
                  end else if (!have_last_ff) begin
                     last_ff      <= req_data.mid_quote;
                     have_last_ff <= 1'b1;
                     state_ff     <= ST_OUT;
                  end else begin
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               if (!rdiv_busy) begin
                  ret_ff   <= ret_sat;
                  last_ff  <= mid_ff;
                  state_ff <= ST_CHK;
               end
            end
            ST_CHK: begin
               state_ff <= need_drop ? ST_DRD : ST_INS;
            end
            ST_DRD: begin
               old_ff   <= RET_W'(rd_data);
               sq_ff    <= SQ_W'(sq_full);
               state_ff <= ST_DUPD;
            end
            ST_DUPD: begin
               sum_ff    <= sum_ff - SUM_W'(old_ff);
               sqsum_ff  <= sqsum_ff - sq_ff;
               filled_ff <= filled_ff - 1'b1;
               state_ff  <= ST_CHK;
            end
            ST_INS: begin
               head_ff   <= (head_ff == AW'(MAX_WINDOW - 1)) ? '0 : head_ff + 1'b1;
               filled_ff <= filled_ff + 1'b1;
               sum_ff    <= sum_ff + SUM_W'(ret_ff);
               sq_ff     <= SQ_W'(sq_full);
               state_ff  <= ST_INS2;
            end
            ST_INS2: begin
               sqsum_ff <= sqsum_ff + sq_ff;
               state_ff <= ST_MSTART;
            end
            ST_MSTART: begin
               n2_ff    <= N2_W'(filled_ff) * N2_W'(filled_ff);
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               if (!mula_busy && !mulb_busy) begin
                  res_valid_ff <= 1'b1;
                  if (big_a <= big_b) begin
                     res_std_ff <= '0;
                     state_ff   <= ST_OUT;
                  end else begin
                     diff_ff  <= big_a - big_b;
                     state_ff <= ST_DSTART;
                  end
               end
            end
            ST_DSTART: begin
               state_ff <= ST_VDIV;
            end
            ST_VDIV: begin
               if (!vdiv_busy) begin
                  state_ff <= ST_SQRT;
               end
            end
            ST_SQRT: begin
               if (!sqrt_busy) begin
                  res_std_ff <= (32'(sqrt_root) > 32'(STD_MAX)) ? STD_MAX
                                                               : STD_W'(sqrt_root);
                  state_ff   <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Output register: a finished item waits here until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff.std_valid    <= res_valid_ff;
         rsp_data_ff.std_value    <= res_std_ff;
         rsp_data_ff.return_count <= CNT_OUT_W'(filled_ff);
         rsp_data_ff.bad_price    <= res_bad_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/rrs_checker.sv =====
// Port-level checks of the rolling return standard deviation block and their binding.
module rrs_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rrs_pkg::rsp_type rsp_data
);

   import rrs_pkg::*;

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item present right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   a_idle_std_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.std_valid |-> rsp_data.std_value == '0)
      else $error("std_value nonzero without std_valid");

   a_valid_not_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.std_valid |-> !rsp_data.bad_price
                                          && rsp_data.return_count != '0)
      else $error("valid std with rejected price or empty window");

endmodule

bind rolling_return_stddev_top rrs_checker u_rrs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== sim/tb_rolling_return_stddev_top.sv =====
// Self-checking testbench for the rolling return standard deviation block.
`timescale 1ns / 100ps

module tb_rolling_return_stddev_top;
   import rrs_pkg::*;

   localparam int RING_DEPTH = 1024;
   localparam int QFRAC      = 24;
   localparam longint RET_HI = (64'sd1 <<< (QFRAC + 3)) - 1;
   localparam longint RET_LO = -(64'sd1 <<< (QFRAC + 3));
   localparam int CYCLE_LIMIT = 4000000;
   localparam int EXP_DEPTH   = 64;
   localparam int HOLD_CYCLES = 1500;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_W-1:0] csr_data = '0;

   rolling_return_stddev_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // Predictor state: a private copy of the window and its running sums.
   logic [CSR_W-1:0] win_len = WIN_RESET;
   logic [31:0] prev_mid = '0;
   bit          prev_known = 1'b0;
   longint      ret_ring [RING_DEPTH];
   int          ring_wr = 0;
   int          ring_fill = 0;
   longint      ret_total = 0;
   logic [63:0] ret_sq_total = '0;

   // Expected results in order: the sender writes, the checker reads.
   rsp_type exp_fifo [EXP_DEPTH];
   int      exp_wr = 0;
   int      exp_rd = 0;
   bit      failed = 1'b0;
   bit      no_idle = 1'b0;     // when set, neither side inserts gaps
   bit      keep_window = 1'b0; // when set, no clears and no zero prices are sent
   int      hold_req = 0;       // bumped by a test to start a long receiver hold-off
   int      hold_ack = 0;
   int      hold_left = 0;      // long receiver hold-off, in cycles
   int      cycle_count = 0;
   logic [31:0] walk_mid = 32'd200000;

   // Run-away guard: the slowest legal run is far below this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d items outstanding", $time, exp_wr - exp_rd);
         $display("** rolling_return_stddev_top: FAILED **");
         $finish;
      end
   end

   function automatic logic [63:0] abs_of(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] b;
      root = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v = v - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   // Population std of the returns held in the window, floor, Q.24.
   function automatic logic [STD_W-1:0] window_std_dev();
      logic [127:0] n_sq, sum_sq, diff, quot;
      logic [63:0]  var_fix, root, s1;
      if (ring_fill == 0) return '0;
      n_sq = 128'(ret_sq_total) * 128'(ring_fill);
      s1 = abs_of(ret_total);
      sum_sq = 128'(s1) * 128'(s1);
      if (n_sq <= sum_sq) return '0;
      diff = n_sq - sum_sq;
      quot = diff / (128'(ring_fill) * 128'(ring_fill));
      var_fix = (quot[127:64] != 0) ? '1 : quot[63:0];
      root = int_sqrt(var_fix);
      return (root > 64'(STD_MAX)) ? STD_MAX : root[STD_W-1:0];
   endfunction

   function automatic rsp_type predict_std(req_type it);
      rsp_type r;
      longint diff, ret, oldest;
      int lim, idx;
      r = '0;
      if (it.cmd == CMD_CLEAR) begin
         prev_mid = '0; prev_known = 1'b0; ring_wr = 0; ring_fill = 0;
         ret_total = 0; ret_sq_total = '0;
      end else if (it.mid_quote == 0) begin
         r.bad_price = 1'b1;
      end else if (!prev_known) begin
         prev_mid = it.mid_quote; prev_known = 1'b1;
      end else begin
         diff = longint'({32'd0, it.mid_quote}) - longint'({32'd0, prev_mid});
         ret = (diff * (64'sd1 <<< QFRAC)) / longint'({32'd0, prev_mid});
         if (ret > RET_HI) ret = RET_HI;
         if (ret < RET_LO) ret = RET_LO;
         prev_mid = it.mid_quote;
         lim = int'(win_len);
         if (lim == 0) lim = 1;
         if (lim > RING_DEPTH) lim = RING_DEPTH;
         while (ring_fill >= lim) begin
            idx = (ring_wr + RING_DEPTH - ring_fill) % RING_DEPTH;
            oldest = ret_ring[idx];
            ret_total -= oldest;
            ret_sq_total -= abs_of(oldest) * abs_of(oldest);
            ring_fill--;
         end
         ret_ring[ring_wr] = ret;
         ring_wr = (ring_wr + 1) % RING_DEPTH;
         ring_fill++;
         ret_total += ret;
         ret_sq_total += abs_of(ret) * abs_of(ret);
         r.std_valid = 1'b1;
         r.std_value = window_std_dev();
      end
      r.return_count = ring_fill[CNT_OUT_W-1:0];
      return r;
   endfunction

   // Result checker and receiver stalls, one nonblocking write per cycle.
   int rx_wait = 0;
   always @(posedge clock) begin
      rsp_type exp_r;
      if (hold_req != hold_ack) begin
         hold_ack  <= hold_req;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (exp_wr == exp_rd) begin
            $display("%0t: unexpected result item %h", $time, rsp_data);
            failed = 1'b1;
         end else begin
            exp_r = exp_fifo[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (exp_r.std_valid !== rsp_data.std_valid) begin
               $display("%0t: std_valid expected %0d actual %0d",
                        $time, exp_r.std_valid, rsp_data.std_valid);
               failed = 1'b1;
            end
            if (exp_r.std_value !== rsp_data.std_value) begin
               $display("%0t: std_value expected %0d actual %0d",
                        $time, exp_r.std_value, rsp_data.std_value);
               failed = 1'b1;
            end
            if (exp_r.return_count !== rsp_data.return_count) begin
               $display("%0t: return_count expected %0d actual %0d",
                        $time, exp_r.return_count, rsp_data.return_count);
               failed = 1'b1;
            end
            if (exp_r.bad_price !== rsp_data.bad_price) begin
               $display("%0t: bad_price expected %0d actual %0d",
                        $time, exp_r.bad_price, rsp_data.bad_price);
               failed = 1'b1;
            end
         end
         rx_wait = no_idle ? 0 : $urandom_range(0, 5);
      end else if (rx_wait > 0) begin
         rx_wait--;
      end
      rsp_stall <= (hold_left > 1) || (rx_wait > 0);
   end

   // Offers one item after a random gap and records its expected result once taken.
   task automatic send_item(logic cmd, logic [31:0] mid);
      int gap;
      req_type it;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      it.cmd = cmd;
      it.mid_quote = mid;
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      exp_fifo[exp_wr % EXP_DEPTH] = predict_std(it);
      exp_wr++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (exp_wr == exp_rd);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_window(logic [CSR_W-1:0] len);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      win_len = len;
   endtask

   // Mostly a random walk of plausible prices, with clears, zeros and wild jumps.
   task automatic send_market_item();
      int pick;
      longint nxt, step;
      pick = $urandom_range(0, 99);
      if (pick < 2 && !keep_window) begin
         send_item(CMD_CLEAR, $urandom());
      end else if (pick < 5 && !keep_window) begin
         send_item(CMD_PUSH, 32'd0);
      end else if (pick < 10) begin
         walk_mid = $urandom();
         if (walk_mid == 0) walk_mid = 32'd1;
         send_item(CMD_PUSH, walk_mid);
      end else begin
         step = longint'($urandom_range(0, 64)) + longint'(walk_mid >> $urandom_range(6, 14));
         nxt = $urandom_range(0, 1) ? longint'(walk_mid) + step : longint'(walk_mid) - step;
         if (nxt < 1) nxt = 1;
         if (nxt > 64'hFFFF_FFFF) nxt = 64'hFFFF_FFFF;
         walk_mid = nxt[31:0];
         send_item(CMD_PUSH, walk_mid);
      end
   endtask

   // Extremes of the price, the first price, zero prices, clears and saturating returns.
   task automatic test_directed();
      send_item(CMD_PUSH, 32'd0);          // zero before any price
      send_item(CMD_PUSH, 32'd1);          // first price, no std yet
      send_item(CMD_PUSH, 32'hFFFF_FFFF);  // huge rise saturates positive
      send_item(CMD_PUSH, 32'd1);          // fall close to -1.0
      send_item(CMD_PUSH, 32'd1);          // flat return
      send_item(CMD_PUSH, 32'd0);          // rejected, window kept
      send_item(CMD_PUSH, 32'd9);
      send_item(CMD_CLEAR, 32'hFFFF_FFFF); // clear with a nonzero price attached
      send_item(CMD_PUSH, 32'h8000_0000);
      send_item(CMD_PUSH, 32'h8000_0001);
      send_item(CMD_PUSH, 32'h5555_5555);
      send_item(CMD_PUSH, 32'hAAAA_AAAA);
      send_item(CMD_CLEAR, 32'd0);
      send_item(CMD_PUSH, 32'd3);
      send_item(CMD_PUSH, 32'd100);
      send_item(CMD_PUSH, 32'd2);
   endtask

   // Sweeps the window length through its extremes, including out-of-range codes.
   task automatic test_window_lengths();
      logic [CSR_W-1:0] lens [8] = '{11'd1, 11'd0, 11'd2, 11'd2047, 11'd3, 11'd1025,
                                     11'd17, 11'd1024};
      foreach (lens[i]) begin
         write_window(lens[i]);
         repeat (12) send_market_item();
      end
   endtask

   // The receiver holds off for a long stretch while prices keep coming.
   task automatic test_backpressure();
      write_window(11'd8);
      @(posedge clock);
      hold_req++;
      repeat (20) send_market_item();
      no_idle = 1'b1;
      repeat (40) send_market_item();
      no_idle = 1'b0;
   endtask

   // Long run without clears that fills the whole ring and wraps its head, then a shrink
   // that drops most returns.
   task automatic test_random_walk();
      write_window(11'd1024);
      keep_window = 1'b1;
      repeat (1040) send_market_item();
      keep_window = 1'b0;
      write_window(11'd5);
      repeat (30) send_market_item();
      write_window(11'd64);
      no_idle = 1'b1;
      repeat (20) send_market_item();
      no_idle = 1'b0;
      repeat (20) send_market_item();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_window_lengths();
      test_backpressure();
      test_random_walk();
      wait_idle();
      repeat (300) @(posedge clock);
      if (!failed && exp_wr == exp_rd)
         $display("** rolling_return_stddev_top: PASSED **");
      else
         $display("** rolling_return_stddev_top: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/rrs_pkg.sv
hw/rtl/rrs_ring.sv
hw/rtl/rrs_div.sv
hw/rtl/rrs_mul.sv
hw/rtl/rrs_sqrt.sv
hw/rtl/rolling_return_stddev_top.sv
hw/rtl/rrs_checker.sv
sim/tb_rolling_return_stddev_top.sv
